[rtl/core/kmrq_pkg.sv]
// Shared types, constants and helper functions for the keyboard and mouse response queue.
`timescale 1ns / 1ps

package kmrq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Screen geometry
    localparam int SCREEN_WIDTH  = 720;
    localparam int SCREEN_HEIGHT = 364;
    localparam int POS_X_W       = 10;
    localparam int POS_Y_W       = 9;

    // Pending byte buffer: longest response sequence is five bytes
    localparam int BUF_BYTES = 5;
    localparam int BUF_W     = 8 * BUF_BYTES;
    localparam int LEN_W     = $clog2(BUF_BYTES + 1);

    // Response bytes
    localparam logic [7:0] BYTE_GREET0  = 8'h80;
    localparam logic [7:0] BYTE_GREET1  = 8'h2F;
    localparam logic [7:0] BYTE_CLK_HDR = 8'hE0 | 8'h06;
    localparam logic [7:0] BYTE_ONE     = 8'h01;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_STATUS  = 8'h10;
    localparam logic [7:0] BYTE_EMPTY   = 8'hFF;
    localparam logic [7:0] CMD_CLOCK    = 8'h01;
    localparam logic [7:0] KEY_MASK     = 8'h7F;
    localparam logic [7:0] KEY_UP_BIT   = 8'h80;

    typedef enum logic [2:0] {
        OP_STATUS   = 3'd0,
        OP_DATA_RD  = 3'd1,
        OP_CMD_WR   = 3'd2,
        OP_CTRL_WR  = 3'd3,
        OP_KEY_DOWN = 3'd4,
        OP_KEY_UP   = 3'd5,
        OP_MOVE     = 3'd6,
        OP_RESET    = 3'd7
    } op_t;

    // Memory access request from controller to queue store
    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } mem_req_t;

    // Finished result handed to the output register
    typedef struct packed {
        logic [7:0]       read_value;
        logic             data_pulse;
        logic [CNT_W-1:0] queue_level;
    } res_t;

    // Saturate a 16-bit signed delta to a signed byte
    function automatic logic signed [7:0] clamp_delta(input logic signed [15:0] v);
        logic signed [7:0] r;
        if (v < -16'sd128)
            r = -8'sd128;
        else if (v > 16'sd127)
            r = 8'sd127;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

[rtl/core/kmrq_ram.sv]
// Response byte store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module kmrq_ram
(
    input  logic              clk,
    input  kmrq_pkg::mem_req_t req,
    output logic [7:0]        rdata
);
    import kmrq_pkg::*;

    logic [7:0] mem [QUEUE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/kmrq_pos.sv]
// Pointer position tracker: adds clamped deltas and clamps to the screen.
`timescale 1ns / 1ps

module kmrq_pos
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic signed [7:0]           dx,
    input  logic signed [7:0]           dy,
    output logic [kmrq_pkg::POS_X_W-1:0] pos_x,
    output logic [kmrq_pkg::POS_Y_W-1:0] pos_y
);
    import kmrq_pkg::*;

    localparam int XS_W = POS_X_W + 2;
    localparam int YS_W = POS_Y_W + 2;
    localparam logic signed [XS_W-1:0] X_MAX = XS_W'(SCREEN_WIDTH - 1);
    localparam logic signed [YS_W-1:0] Y_MAX = YS_W'(SCREEN_HEIGHT - 1);

    logic [POS_X_W-1:0]     pos_x_reg, pos_x_next;
    logic [POS_Y_W-1:0]     pos_y_reg, pos_y_next;
    logic signed [XS_W-1:0] sum_x;
    logic signed [YS_W-1:0] sum_y;

    always_comb
    begin
        sum_x = $signed({2'b00, pos_x_reg}) + XS_W'(dx);
        sum_y = $signed({2'b00, pos_y_reg}) + YS_W'(dy);

        if (sum_x < 0)
            pos_x_next = '0;
        else if (sum_x > X_MAX)
            pos_x_next = X_MAX[POS_X_W-1:0];
        else
            pos_x_next = sum_x[POS_X_W-1:0];

        if (sum_y < 0)
            pos_y_next = '0;
        else if (sum_y > Y_MAX)
            pos_y_next = Y_MAX[POS_Y_W-1:0];
        else
            pos_y_next = sum_y[POS_Y_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end
        else if (en)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;

endmodule

[rtl/core/kmrq_ctrl.sv]
// Queue controller: decodes items, sequences byte pushes and pops against the store.
`timescale 1ns / 1ps

module kmrq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         opcode,
    input  logic [7:0]         data_byte,
    input  logic [7:0]         port_direction,
    input  logic [7:0]         key_code,
    input  logic signed [15:0] move_x,
    input  logic signed [15:0] move_y,
    output logic               res_valid,
    input  logic               res_ready,
    output kmrq_pkg::res_t     res,
    output kmrq_pkg::mem_req_t mem_req,
    input  logic [7:0]         mem_rdata,
    output logic               pos_en,
    output logic signed [7:0]  pos_dx,
    output logic signed [7:0]  pos_dy
);
    import kmrq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_READ,
        ST_DONE
    } state_t;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    state_t           state_reg;
    logic             boot_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [BUF_W-1:0] buf_reg;
    logic [LEN_W-1:0] len_reg;
    logic             pulse_reg;
    logic [7:0]       rv_reg;

    op_t              op;
    logic             accept;
    logic             room;
    logic             move_nz;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;

    assign op         = op_t'(opcode);
    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign room       = (cnt_reg < CNT_FULL);
    assign move_nz    = (move_x != 16'sd0) || (move_y != 16'sd0);
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;

    assign pos_dx = clamp_delta(move_x);
    assign pos_dy = clamp_delta(move_y);
    assign pos_en = accept && (op == OP_MOVE) && move_nz;

    always_comb
    begin
        mem_req.we    = (state_reg == ST_PUSH) && room;
        mem_req.waddr = wr_ptr_reg;
        mem_req.wdata = buf_reg[7:0];
        mem_req.re    = accept && (op == OP_DATA_RD) && (cnt_reg != '0);
        mem_req.raddr = rd_ptr_reg;
    end

    assign res_valid       = (state_reg == ST_DONE);
    assign res.read_value  = rv_reg;
    assign res.data_pulse  = pulse_reg;
    assign res.queue_level = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // power-on greeting goes through the normal push sequence
            state_reg  <= ST_PUSH;
            boot_reg   <= 1'b1;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
            buf_reg    <= BUF_W'({BYTE_GREET1, BYTE_GREET0});
            len_reg    <= LEN_W'(2);
            pulse_reg  <= 1'b0;
            rv_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (op)
                            OP_STATUS:
                            begin
                                rv_reg    <= BYTE_STATUS | {7'd0, (cnt_reg != '0)};
                                pulse_reg <= 1'b0;
                                state_reg <= ST_DONE;
                            end
                            OP_DATA_RD:
                            begin
                                pulse_reg <= 1'b0;
                                if (cnt_reg == '0)
                                begin
                                    rv_reg    <= BYTE_EMPTY;
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    // read value lands in ST_READ
                                    state_reg <= ST_READ;
                                end
                            end
                            OP_CMD_WR:
                            begin
                                rv_reg    <= '0;
                                pulse_reg <= 1'b0;
                                if (data_byte == CMD_CLOCK)
                                begin
                                    buf_reg   <= {BYTE_ZERO, BYTE_ZERO, BYTE_ONE, BYTE_ONE,
                                                  BYTE_CLK_HDR};
                                    len_reg   <= LEN_W'(5);
                                    state_reg <= ST_PUSH;
                                end
                                else
                                begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            OP_CTRL_WR:
                            begin
                                rv_reg    <= '0;
                                pulse_reg <= 1'b0;
                                if (port_direction[0] && !data_byte[0])
                                begin
                                    buf_reg   <= BUF_W'({BYTE_GREET1, BYTE_GREET0});
                                    len_reg   <= LEN_W'(2);
                                    state_reg <= ST_PUSH;
                                end
                                else
                                begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            OP_KEY_DOWN, OP_KEY_UP:
                            begin
                                rv_reg <= '0;
                                if (!key_code[7])
                                begin
                                    buf_reg   <= BUF_W'((op == OP_KEY_UP) ?
                                                        (key_code | KEY_UP_BIT) :
                                                        (key_code & KEY_MASK));
                                    len_reg   <= LEN_W'(1);
                                    pulse_reg <= 1'b1;
                                    state_reg <= ST_PUSH;
                                end
                                else
                                begin
                                    pulse_reg <= 1'b0;
                                    state_reg <= ST_DONE;
                                end
                            end
                            OP_MOVE:
                            begin
                                rv_reg <= '0;
                                if (move_nz)
                                begin
                                    buf_reg   <= BUF_W'({pos_dy, pos_dx});
                                    len_reg   <= LEN_W'(2);
                                    pulse_reg <= 1'b1;
                                    state_reg <= ST_PUSH;
                                end
                                else
                                begin
                                    pulse_reg <= 1'b0;
                                    state_reg <= ST_DONE;
                                end
                            end
                            OP_RESET:
                            begin
                                rv_reg     <= '0;
                                rd_ptr_reg <= '0;
                                wr_ptr_reg <= '0;
                                cnt_reg    <= '0;
                                buf_reg    <= BUF_W'({BYTE_GREET1, BYTE_GREET0});
                                len_reg    <= LEN_W'(2);
                                pulse_reg  <= 1'b1;
                                state_reg  <= ST_PUSH;
                            end
                            default:
                            begin
                                rv_reg    <= '0;
                                pulse_reg <= 1'b0;
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_PUSH:
                begin
                    // bytes beyond a full queue are dropped
                    if (room)
                    begin
                        wr_ptr_reg <= wr_ptr_inc;
                        cnt_reg    <= cnt_reg + 1'b1;
                        pulse_reg  <= 1'b1;
                    end
                    buf_reg <= buf_reg >> 8;
                    len_reg <= len_reg - 1'b1;
                    if (len_reg == LEN_W'(1))
                    begin
                        boot_reg  <= 1'b0;
                        state_reg <= boot_reg ? ST_IDLE : ST_DONE;
                    end
                end
                ST_READ:
                begin
                    rv_reg     <= mem_rdata;
                    rd_ptr_reg <= rd_ptr_inc;
                    cnt_reg    <= cnt_reg - 1'b1;
                    state_reg  <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (res_ready)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("queue level beyond depth");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("store write without level increment");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.re |=> (state_reg == ST_READ) && (cnt_reg != '0))
        else $error("pop issued on empty queue");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second item taken while one in flight");

    a_boot_silent: assert property (@(posedge clk) disable iff (!rst_n)
        boot_reg |-> !res_valid)
        else $error("result raised during power-on greeting");

endmodule

[rtl/core/keyboard_mouse_response_queue.sv]
// Top level of the keyboard and mouse response queue with its output register.
`timescale 1ns / 1ps
// Path: status reads and ignored items go straight to the result; a data read goes through
//   a store read; key events, moves, qualified control writes, clock commands push bytes.
// Throughput: one item at a time; the next item is taken once the result has moved into
//   the output register, so a waiting result does not block the input. Pushes run at one
//   byte a cycle through the single write port of the response store.
// Reset: asynchronous, active low. After release the controller writes the greeting bytes
//   0x80, 0x2F into the store with s_tready low; pointer at (0,0).

module keyboard_mouse_response_queue
(
    input  logic        clk,
    input  logic        rst_n,
    // Input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // data_byte[7:0], port_direction[15:8], key_code[23:16],
                                   // move_x[39:24], move_y[55:40]
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    // Result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_value[7:0], data_pulse[8], pointer_x[18:9],
                                   // pointer_y[27:19], queue_level[33:28], zero[39:34]
);
    import kmrq_pkg::*;

    localparam int OUT_FIELDS_W = 8 + 1 + POS_X_W + POS_Y_W + 6;

    mem_req_t           mem_req;
    logic [7:0]         mem_rdata;
    res_t               res;
    logic               res_valid;
    logic               res_ready;
    logic               pos_en;
    logic signed [7:0]  pos_dx;
    logic signed [7:0]  pos_dy;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;

    // Output register: parts the result side from the controller
    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;

    // The register frees when empty or when its transfer completes this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    kmrq_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .opcode         (s_tuser),
        .data_byte      (s_tdata[7:0]),
        .port_direction (s_tdata[15:8]),
        .key_code       (s_tdata[23:16]),
        .move_x         (s_tdata[39:24]),
        .move_y         (s_tdata[55:40]),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .mem_req        (mem_req),
        .mem_rdata      (mem_rdata),
        .pos_en         (pos_en),
        .pos_dx         (pos_dx),
        .pos_dy         (pos_dy)
    );

    kmrq_ram u_ram
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    kmrq_pos u_pos
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (pos_en),
        .dx    (pos_dx),
        .dy    (pos_dy),
        .pos_x (pos_x),
        .pos_y (pos_y)
    );

    // Pack the result; the pointer is already final once the item is in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= 40'({6'(res.queue_level), pos_y, pos_x,
                                res.data_pulse, res.read_value});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_out_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39:OUT_FIELDS_W] == '0))
        else $error("padding bits of result not zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !(res_valid && res_ready))
        else $error("result loaded over a waiting one");

endmodule
